### hdl/psq_pkg.sv
// ----------------------------------------------------------------------------
// psq_pkg
// Types and codes shared by the positional sequence store modules.
// ----------------------------------------------------------------------------
`default_nettype none

package psq_pkg;

  localparam int DataWidth = 32;

  typedef enum logic [2:0] {
    CMD_SET        = 3'd0,
    CMD_GET        = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_DELETE_AT  = 3'd3,
    CMD_PUSH_FRONT = 3'd4,
    CMD_PUSH_BACK  = 3'd5,
    CMD_POP_FRONT  = 3'd6,
    CMD_POP_BACK   = 3'd7
  } psq_cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } psq_status_e;

  typedef struct packed {
    psq_cmd_e              cmd;
    logic [6:0]            position;
    logic signed [31:0]    item_value;
  } psq_req_t;

  typedef struct packed {
    logic signed [31:0]    read_value;
    logic [6:0]            seq_length;
    psq_status_e           status;
  } psq_rsp_t;

endpackage

`default_nettype wire

### hdl/positional_sequence_store.sv
// ----------------------------------------------------------------------------
// positional_sequence_store
// Fixed-capacity ordered sequence with set, get, insert and delete at a
// position and push and pop at both ends, kept as a circular buffer.
// ----------------------------------------------------------------------------
//
//   channel   valid        stall        payload
//   request   in_valid_i   in_stall_o   in_req_i   (psq_req_t)
//   response  out_valid_o  out_stall_i  out_rsp_o  (psq_rsp_t)
//
// set, push: the write happens in the execute state; get, pop: the read data is
// registered in a read-result state. Insert and delete at a position inside the
// sequence move one entry per cycle through the single write port of the memory.
// reset clears state, head, length and output valid, not the items; the store needs no clearing pass.
// in_stall_o is high while a request is in progress; a finished response
// waits in the output register, and the next request may start meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_sequence_store #(
  parameter int CAPACITY = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire psq_pkg::psq_req_t  in_req_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      psq_pkg::psq_rsp_t  out_rsp_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                           res_valid;
  psq_pkg::psq_rsp_t              res;
  logic                           res_taken;
  logic                           mem_we;
  logic [IW-1:0]                  mem_waddr;
  logic [psq_pkg::DataWidth-1:0]  mem_wdata;
  logic                           mem_re;
  logic [IW-1:0]                  mem_raddr;
  logic [psq_pkg::DataWidth-1:0]  mem_rdata;

  logic               out_valid_q;
  psq_pkg::psq_rsp_t  out_rsp_q;

  psq_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_i       (in_req_i),
    .req_stall_o (in_stall_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_taken_i (res_taken),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  psq_mem #(
    .DEPTH(CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // load when the output register is empty or drains this cycle
  assign res_taken = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_taken) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_taken) begin
      out_rsp_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

### hdl/psq_mem.sv
// ----------------------------------------------------------------------------
// psq_mem
// Item storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_mem #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [AW-1:0]                  waddr_i,
  input  wire logic [psq_pkg::DataWidth-1:0]  wdata_i,
  input  wire logic                           re_i,
  input  wire logic [AW-1:0]                  raddr_i,
  output      logic [psq_pkg::DataWidth-1:0]  rdata_o
);

  logic [psq_pkg::DataWidth-1:0] mem_q [DEPTH];
  logic [psq_pkg::DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/psq_ctrl.sv
// ----------------------------------------------------------------------------
// psq_ctrl
// Command sequencer: decodes a request, checks bounds, and walks the memory
// one entry per cycle for positional insert and delete.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_ctrl #(
  parameter int CAPACITY = 64,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           req_valid_i,
  input  wire psq_pkg::psq_req_t              req_i,
  output      logic                           req_stall_o,
  output      logic                           res_valid_o,
  output      psq_pkg::psq_rsp_t              res_o,
  input  wire logic                           res_taken_i,
  output      logic                           mem_we_o,
  output      logic [IW-1:0]                  mem_waddr_o,
  output      logic [psq_pkg::DataWidth-1:0]  mem_wdata_o,
  output      logic                           mem_re_o,
  output      logic [IW-1:0]                  mem_raddr_o,
  input  wire logic [psq_pkg::DataWidth-1:0]  mem_rdata_i
);

  localparam int LW = ((CW > 7) ? CW : 7) + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDRES  = 3'd2;
  localparam logic [2:0] S_ISHIFT = 3'd3;
  localparam logic [2:0] S_IFILL  = 3'd4;
  localparam logic [2:0] S_DSHIFT = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]                   state_q, state_d;
  psq_pkg::psq_cmd_e            cmd_q, cmd_d;
  logic [6:0]                   pos_q, pos_d;
  logic [psq_pkg::DataWidth-1:0] val_q, val_d;
  logic [IW-1:0]                head_q, head_d;
  logic [CW-1:0]                count_q, count_d;
  logic [CW-1:0]                k_q, k_d;
  logic [psq_pkg::DataWidth-1:0] rd_q, rd_d;
  psq_pkg::psq_status_e         st_q, st_d;

  logic [LW-1:0] pos_l, cnt_l;
  logic [CW-1:0] pm1;
  logic          pos_ok, ins_ok, full, empty;
  logic [IW-1:0] head_dec, head_inc;

  // physical slot of logical index k, k never beyond the capacity
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] head,
                                         input logic [CW-1:0] k);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(k);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  assign pos_l    = LW'(pos_q);
  assign cnt_l    = LW'(count_q);
  assign pm1      = CW'(pos_l - LW'(1));
  assign pos_ok   = (pos_q != 7'd0) && (pos_l <= cnt_l);
  assign ins_ok   = (pos_q != 7'd0) && (pos_l <= cnt_l + LW'(1));
  assign full     = (count_q == CW'(CAPACITY));
  assign empty    = (count_q == '0);
  assign head_dec = (head_q == '0) ? IW'(CAPACITY - 1) : head_q - IW'(1);
  assign head_inc = (head_q == IW'(CAPACITY - 1)) ? '0 : head_q + IW'(1);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    pos_d       = pos_q;
    val_d       = val_q;
    head_d      = head_q;
    count_d     = count_q;
    k_d         = k_q;
    rd_d        = rd_q;
    st_d        = st_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = val_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_d   = req_i.cmd;
          pos_d   = req_i.position;
          val_d   = req_i.item_value;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        rd_d    = '0;
        st_d    = psq_pkg::ST_OK;
        state_d = S_DONE;
        unique case (cmd_q)
          psq_pkg::CMD_SET: begin
            if (!pos_ok) begin
              st_d = psq_pkg::ST_BADPOS;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = slot(head_q, pm1);
            end
          end
          psq_pkg::CMD_GET: begin
            if (!pos_ok) begin
              st_d = psq_pkg::ST_BADPOS;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = slot(head_q, pm1);
              state_d     = S_RDRES;
            end
          end
          psq_pkg::CMD_INSERT_AT: begin
            if (!ins_ok) begin
              st_d = psq_pkg::ST_BADPOS;
            end else if (full) begin
              st_d = psq_pkg::ST_FULL;
            end else if (pm1 == count_q) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = slot(head_q, count_q);
              count_d     = count_q + CW'(1);
            end else begin
              // move the tail back, last item first
              mem_re_o    = 1'b1;
              mem_raddr_o = slot(head_q, count_q - CW'(1));
              k_d         = count_q;
              state_d     = S_ISHIFT;
            end
          end
          psq_pkg::CMD_DELETE_AT: begin
            if (empty) begin
              st_d = psq_pkg::ST_EMPTY;
            end else if (!pos_ok) begin
              st_d = psq_pkg::ST_BADPOS;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = slot(head_q, pm1);
              k_d         = pm1;
              state_d     = S_RDRES;
            end
          end
          psq_pkg::CMD_PUSH_FRONT: begin
            if (full) begin
              st_d = psq_pkg::ST_FULL;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = head_dec;
              head_d      = head_dec;
              count_d     = count_q + CW'(1);
            end
          end
          psq_pkg::CMD_PUSH_BACK: begin
            if (full) begin
              st_d = psq_pkg::ST_FULL;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = slot(head_q, count_q);
              count_d     = count_q + CW'(1);
            end
          end
          psq_pkg::CMD_POP_FRONT: begin
            if (empty) begin
              st_d = psq_pkg::ST_EMPTY;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = head_q;
              head_d      = head_inc;
              count_d     = count_q - CW'(1);
              state_d     = S_RDRES;
            end
          end
          psq_pkg::CMD_POP_BACK: begin
            if (empty) begin
              st_d = psq_pkg::ST_EMPTY;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = slot(head_q, count_q - CW'(1));
              count_d     = count_q - CW'(1);
              state_d     = S_RDRES;
            end
          end
          default: begin
            st_d = psq_pkg::ST_OK;
          end
        endcase
      end

      S_RDRES: begin
        rd_d    = mem_rdata_i;
        state_d = S_DONE;
        if (cmd_q == psq_pkg::CMD_DELETE_AT) begin
          if ((CW+1)'(k_q) + (CW+1)'(1) < (CW+1)'(count_q)) begin
            // close the gap, first follower first
            mem_re_o    = 1'b1;
            mem_raddr_o = slot(head_q, k_q + CW'(1));
            state_d     = S_DSHIFT;
          end else begin
            count_d = count_q - CW'(1);
          end
        end
      end

      S_DSHIFT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = slot(head_q, k_q);
        mem_wdata_o = mem_rdata_i;
        if ((CW+1)'(k_q) + (CW+1)'(2) < (CW+1)'(count_q)) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = slot(head_q, k_q + CW'(2));
          k_d         = k_q + CW'(1);
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end

      S_ISHIFT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = slot(head_q, k_q);
        mem_wdata_o = mem_rdata_i;
        if (LW'(k_q) > pos_l) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = slot(head_q, k_q - CW'(2));
          k_d         = k_q - CW'(1);
        end else begin
          state_d = S_IFILL;
        end
      end

      S_IFILL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = slot(head_q, pm1);
        count_d     = count_q + CW'(1);
        state_d     = S_DONE;
      end

      S_DONE: begin
        if (res_taken_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    pos_q <= pos_d;
    val_q <= val_d;
    k_q   <= k_d;
    rd_q  <= rd_d;
    st_q  <= st_d;
  end

  assign req_stall_o      = (state_q != S_IDLE);
  assign res_valid_o      = (state_q == S_DONE);
  assign res_o.read_value = rd_q;
  assign res_o.seq_length = cnt_l[6:0];
  assign res_o.status     = st_q;

endmodule

`default_nettype wire
